// File: sv/assert_macros.svh
// Assertion macros shared by the box overlap RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/biou_pkg.sv
// Shared constants, payload types and span helper for the box overlap block.
// No dependencies.
package biou_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 16;
    localparam int AREA_BITS     = 2 * COORD_BITS;
    localparam int UNION_BITS    = AREA_BITS + 1;
    localparam int RATIO_BITS    = FRACTION_BITS + 1;
    localparam int DIV_STEPS     = RATIO_BITS;
    localparam int REM_BITS      = UNION_BITS + 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] first_width;
        logic [COORD_BITS-1:0] first_height;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [COORD_BITS-1:0] second_width;
        logic [COORD_BITS-1:0] second_height;
    } t_box_pair;

    typedef struct packed {
        logic [RATIO_BITS-1:0] overlap_ratio;
        logic [AREA_BITS-1:0]  overlap_area;
        logic [UNION_BITS-1:0] union_area;
    } t_iou_result;

    typedef struct packed {
        logic [AREA_BITS-1:0]  overlap_area;
        logic [UNION_BITS-1:0] union_area;
    } t_areas;

    function automatic logic [COORD_BITS-1:0] span_overlap(
        input logic [COORD_BITS-1:0] a_near,
        input logic [COORD_BITS-1:0] a_size,
        input logic [COORD_BITS-1:0] b_near,
        input logic [COORD_BITS-1:0] b_size
    );
        logic [COORD_BITS:0] a_far;
        logic [COORD_BITS:0] b_far;
        logic [COORD_BITS:0] lo;
        logic [COORD_BITS:0] hi;
        logic [COORD_BITS:0] diff;
        a_far = {1'b0, a_near} + {1'b0, a_size};
        b_far = {1'b0, b_near} + {1'b0, b_size};
        lo    = (a_near > b_near) ? {1'b0, a_near} : {1'b0, b_near};
        hi    = (a_far < b_far) ? a_far : b_far;
        diff  = hi - lo;
        return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
    endfunction

endpackage

// File: sv/box_intersection_over_union.sv
// Intersection over union of two axis-aligned boxes.
// Input channel (i_in_valid / o_in_ready / i_in_data): one box pair per
// transaction, each box as x, y, width, height in pixels.
// Output channel (o_out_valid / i_out_ready / o_out_data): overlap ratio as
// unsigned Q1.16 truncated, overlap area and union area.
// Throughput: one transaction per cycle when the receiver keeps up.
// Path from input acceptance to output valid: three front
// stages (spans, 12x12 products, union add), the queue, and
// 17 divider stages, one quotient bit each.
// A four-entry queue sits between the area pipeline and the divider, so
// each half stalls on its own: when i_out_ready is low the divider holds,
// the queue fills, and only then does o_in_ready fall.
// Reset (i_rst_n low, synchronous) empties every stage and the queue;
// no transaction is in flight afterwards.
// Depends on biou_pkg, biou_front, biou_fifo and biou_back.
module box_intersection_over_union (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  biou_pkg::t_box_pair   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output biou_pkg::t_iou_result o_out_data
);

    logic             w_push_valid;
    logic             w_push_ready;
    biou_pkg::t_areas w_push_data;
    logic             w_pop_valid;
    logic             w_pop_ready;
    biou_pkg::t_areas w_pop_data;

    biou_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    biou_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    biou_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_data   (w_pop_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// File: sv/biou_front.sv
// Front pipeline: accepts box pairs, computes spans, areas and union area.
// Depends on biou_pkg and assert_macros.svh.
`include "assert_macros.svh"

module biou_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  biou_pkg::t_box_pair i_in_data,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output biou_pkg::t_areas    o_push_data
);

    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic [biou_pkg::COORD_BITS-1:0]     r_ow;
    logic [biou_pkg::COORD_BITS-1:0]     r_oh;
    logic [biou_pkg::COORD_BITS-1:0]     r_aw;
    logic [biou_pkg::COORD_BITS-1:0]     r_ah;
    logic [biou_pkg::COORD_BITS-1:0]     r_bw;
    logic [biou_pkg::COORD_BITS-1:0]     r_bh;
    logic [biou_pkg::AREA_BITS-1:0]      r_inter;
    logic [biou_pkg::AREA_BITS-1:0]      r_area_a;
    logic [biou_pkg::AREA_BITS-1:0]      r_area_b;
    biou_pkg::t_areas                    r_areas;
    logic [biou_pkg::COORD_BITS-1:0]     n_ow;
    logic [biou_pkg::COORD_BITS-1:0]     n_oh;
    logic [biou_pkg::UNION_BITS-1:0]     n_union;
    logic                                w_en;

    assign w_en       = !r_v3 || i_push_ready;
    assign o_in_ready = w_en;

    assign n_ow = biou_pkg::span_overlap(i_in_data.first_x, i_in_data.first_width,
                                         i_in_data.second_x, i_in_data.second_width);
    assign n_oh = biou_pkg::span_overlap(i_in_data.first_y, i_in_data.first_height,
                                         i_in_data.second_y, i_in_data.second_height);
    assign n_union = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ow                 <= n_ow;
            r_oh                 <= n_oh;
            r_aw                 <= i_in_data.first_width;
            r_ah                 <= i_in_data.first_height;
            r_bw                 <= i_in_data.second_width;
            r_bh                 <= i_in_data.second_height;
            r_inter              <= biou_pkg::AREA_BITS'(r_ow) * biou_pkg::AREA_BITS'(r_oh);
            r_area_a             <= biou_pkg::AREA_BITS'(r_aw) * biou_pkg::AREA_BITS'(r_ah);
            r_area_b             <= biou_pkg::AREA_BITS'(r_bw) * biou_pkg::AREA_BITS'(r_bh);
            r_areas.overlap_area <= r_inter;
            r_areas.union_area   <= n_union;
        end
    end

    assign o_push_valid = r_v3;
    assign o_push_data  = r_areas;

    `ASSERT_IMPL(a_front_overlap_le_union, i_clk, i_rst_n, r_v3, (r_areas.overlap_area <= r_areas.union_area), "overlap area exceeds union area")

endmodule

// File: sv/biou_fifo.sv
// Short queue of area pairs between the front and back pipelines.
// Depends on biou_pkg and assert_macros.svh.
`include "assert_macros.svh"

module biou_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  biou_pkg::t_areas i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output biou_pkg::t_areas o_pop_data
);

    localparam logic [biou_pkg::FIFO_PTR_BITS-1:0] PTR_LAST =
        biou_pkg::FIFO_PTR_BITS'(biou_pkg::FIFO_DEPTH - 1);
    localparam logic [biou_pkg::FIFO_CNT_BITS-1:0] CNT_FULL =
        biou_pkg::FIFO_CNT_BITS'(biou_pkg::FIFO_DEPTH);

    biou_pkg::t_areas                    r_mem [biou_pkg::FIFO_DEPTH];
    logic [biou_pkg::FIFO_PTR_BITS-1:0]  r_wptr;
    logic [biou_pkg::FIFO_PTR_BITS-1:0]  r_rptr;
    logic [biou_pkg::FIFO_CNT_BITS-1:0]  r_count;
    logic                                w_push;
    logic                                w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    `ASSERT_RST(a_fifo_count_bound, i_clk, i_rst_n, (r_count <= CNT_FULL), "queue count above depth")
    `ASSERT_NEXT(a_fifo_count_step, i_clk, i_rst_n, (w_push && !w_pop), (r_count == $past(r_count) + 1'b1), "queue count missed a push")

endmodule

// File: sv/biou_back.sv
// Back pipeline: one restoring division step per stage, overlap over union.
// Depends on biou_pkg and assert_macros.svh.
`include "assert_macros.svh"

module biou_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  biou_pkg::t_areas      i_pop_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output biou_pkg::t_iou_result o_out_data
);

    localparam int LAST = biou_pkg::DIV_STEPS - 1;

    logic [biou_pkg::REM_BITS-1:0]   r_rem [biou_pkg::DIV_STEPS];
    logic [biou_pkg::UNION_BITS-1:0] r_div [biou_pkg::DIV_STEPS];
    logic [biou_pkg::RATIO_BITS-1:0] r_quo [biou_pkg::DIV_STEPS];
    logic [biou_pkg::AREA_BITS-1:0]  r_ovl [biou_pkg::DIV_STEPS];
    logic [biou_pkg::DIV_STEPS-1:0]  r_valid;

    logic [biou_pkg::REM_BITS-1:0]   w_rin  [biou_pkg::DIV_STEPS];
    logic [biou_pkg::UNION_BITS-1:0] w_din  [biou_pkg::DIV_STEPS];
    logic [biou_pkg::RATIO_BITS-1:0] w_qin  [biou_pkg::DIV_STEPS];
    logic [biou_pkg::AREA_BITS-1:0]  w_oin  [biou_pkg::DIV_STEPS];
    logic [biou_pkg::REM_BITS-1:0]   n_rem  [biou_pkg::DIV_STEPS];
    logic [biou_pkg::RATIO_BITS-1:0] n_quo  [biou_pkg::DIV_STEPS];
    logic                            w_en;

    assign w_en        = !r_valid[LAST] || i_out_ready;
    assign o_pop_ready = w_en;

    for (genvar s = 0; s < biou_pkg::DIV_STEPS; s++) begin : g_stage_in
        if (s == 0) begin : g_first
            assign w_rin[s] = biou_pkg::REM_BITS'(i_pop_data.overlap_area);
            assign w_din[s] = i_pop_data.union_area;
            assign w_qin[s] = '0;
            assign w_oin[s] = i_pop_data.overlap_area;
        end else begin : g_next
            assign w_rin[s] = {r_rem[s-1][biou_pkg::REM_BITS-2:0], 1'b0};
            assign w_din[s] = r_div[s-1];
            assign w_qin[s] = r_quo[s-1];
            assign w_oin[s] = r_ovl[s-1];
        end
    end

    always_comb begin
        logic [biou_pkg::REM_BITS-1:0] dext;
        logic                          fits;
        for (int s = 0; s < biou_pkg::DIV_STEPS; s++) begin
            dext     = {1'b0, w_din[s]};
            fits     = (w_rin[s] >= dext);
            n_rem[s] = fits ? (w_rin[s] - dext) : w_rin[s];
            n_quo[s] = {w_qin[s][biou_pkg::RATIO_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[biou_pkg::DIV_STEPS-2:0], i_pop_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < biou_pkg::DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_div[s] <= w_din[s];
                r_ovl[s] <= w_oin[s];
            end
        end
    end

    // empty overlap forces a zero ratio, also covering a zero union
    assign o_out_valid              = r_valid[LAST];
    assign o_out_data.overlap_ratio = (r_ovl[LAST] == '0) ? '0 : r_quo[LAST];
    assign o_out_data.overlap_area  = r_ovl[LAST];
    assign o_out_data.union_area    = r_div[LAST];

    `ASSERT_IMPL(a_back_ratio_bound, i_clk, i_rst_n, o_out_valid, (o_out_data.overlap_ratio <= biou_pkg::RATIO_ONE), "ratio above one")
    `ASSERT_IMPL(a_back_ratio_one, i_clk, i_rst_n, (o_out_valid && (o_out_data.overlap_ratio == biou_pkg::RATIO_ONE)), ({1'b0, o_out_data.overlap_area} == o_out_data.union_area), "ratio of one without full overlap")

endmodule
